// File: rtl/cca_pkg.sv
// cca_pkg: shared constants for the cell count adaptation block
// action, request and register index codes, field widths, register reset values
// no dependencies
package cca_pkg;

  // field widths
  localparam int ACTION_W     = 3;
  localparam int REQUEST_W    = 3;
  localparam int USED_COUNT_W = 16;
  localparam int SCHED_W      = 8;
  localparam int REQUIRED_W   = 9;
  localparam int LIMIT_W      = 11;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 11;

  // counter width default
  localparam int COUNTER_WIDTH_DEFAULT = 16;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_RESET     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_TX_USED   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_RX_USED   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_HOUSEKEEP = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_TRIGGER   = 3'd4;

  // request codes
  localparam logic [REQUEST_W-1:0] REQ_NONE       = 3'd0;
  localparam logic [REQUEST_W-1:0] REQ_ADD_TX     = 3'd1;
  localparam logic [REQUEST_W-1:0] REQ_ADD_RX     = 3'd2;
  localparam logic [REQUEST_W-1:0] REQ_DEL_TX     = 3'd3;
  localparam logic [REQUEST_W-1:0] REQ_DEL_RX     = 3'd4;
  localparam logic [REQUEST_W-1:0] REQ_KEEP_ALIVE = 3'd5;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_CELLS    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_USED_HIGH_LIMIT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_USED_LOW_LIMIT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RX_INIT_HIGH    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TX_MAX_CELLS    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_RX_MAX_CELLS    = 3'd5;

  // configuration reset values
  localparam logic [LIMIT_W-1:0] WINDOW_CELLS_RESET    = 11'd100;
  localparam logic [LIMIT_W-1:0] USED_HIGH_LIMIT_RESET = 11'd75;
  localparam logic [LIMIT_W-1:0] USED_LOW_LIMIT_RESET  = 11'd25;
  localparam logic [LIMIT_W-1:0] RX_INIT_HIGH_RESET    = 11'd75;
  localparam logic [SCHED_W-1:0] TX_MAX_CELLS_RESET    = 8'd16;
  localparam logic [SCHED_W-1:0] RX_MAX_CELLS_RESET    = 8'd16;

endpackage

// File: rtl/cell_count_adaptation.sv
// cell_count_adaptation: TX/RX cell usage tracking and add/delete request selection
// depends on cca_pkg for codes, widths and register reset values
//
// Usage
//   Input channel (in_valid / in_stall) carries one request: reset of the counts,
//   TX used cells, one RX used cell, a housekeeping update or a trigger.
//   Every accepted request gives exactly one result on the output channel
//   (out_valid / out_stall): the request code picked by a trigger (none otherwise),
//   the required TX and RX cell counts and the pending keep-alive flag.
//   Configuration registers are written through cfg_write / cfg_index / cfg_data
//   and must only change while no request is in flight.
// Timing
//   A request is captured in an input register, evaluated there, and its result
//   is loaded into the output register once that register is free, which raises
//   out_valid. One request per cycle is sustained while out_stall is low; the
//   state update and the result load share the single evaluation cycle, so
//   requests see each other's effects without bubbles.
// Reset and stall
//   rst clears all counters, sets required TX to one and restores the register
//   defaults. While out_stall holds a result, the input register still takes
//   one more request; in_stall rises only when both registers are full.

module cell_count_adaptation #(
  parameter int COUNTER_WIDTH = cca_pkg::COUNTER_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // request input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cca_pkg::ACTION_W-1:0]      action,
  input  logic                              clear_required,
  input  logic [cca_pkg::USED_COUNT_W-1:0]  used_count,
  input  logic                              parent_present,
  input  logic [cca_pkg::SCHED_W-1:0]       tx_scheduled_now,
  input  logic [cca_pkg::SCHED_W-1:0]       rx_scheduled_now,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cca_pkg::REQUEST_W-1:0]     request,
  output logic [cca_pkg::REQUIRED_W-1:0]    tx_required_out,
  output logic [cca_pkg::REQUIRED_W-1:0]    rx_required_out,
  output logic                              keep_alive_pending,
  // configuration write port
  input  logic                              cfg_write,
  input  logic [cca_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cca_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import cca_pkg::*;

  localparam int CW   = COUNTER_WIDTH;
  localparam int SW   = ((CW > USED_COUNT_W) ? CW : USED_COUNT_W) + 1;
  localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  typedef struct packed {
    logic [SCHED_W-1:0]    sched;
    logic [REQUIRED_W-1:0] req;
    logic [CW-1:0]         elap;
    logic [CW-1:0]         used;
  } dir_t;

  typedef struct packed {
    dir_t d;
    logic keep;
  } eval_t;

  // configuration registers
  logic [LIMIT_W-1:0] window_cells;
  logic [LIMIT_W-1:0] used_high_limit;
  logic [LIMIT_W-1:0] used_low_limit;
  logic [LIMIT_W-1:0] rx_initial_high_limit;
  logic [SCHED_W-1:0] tx_max_cells;
  logic [SCHED_W-1:0] rx_max_cells;

  // block state
  dir_t tx, tx_next;
  dir_t rx, rx_next;
  logic keep_alive_flag, keep_alive_flag_next;

  // input register
  logic                    s1_valid;
  logic [ACTION_W-1:0]     s1_action;
  logic                    s1_clear_required;
  logic [USED_COUNT_W-1:0] s1_used_count;
  logic                    s1_parent_present;
  logic [SCHED_W-1:0]      s1_tx_now;
  logic [SCHED_W-1:0]      s1_rx_now;

  logic                    out_ready;
  logic                    s1_fire;
  logic [REQUEST_W-1:0]    request_next;
  eval_t                   tx_eval;
  eval_t                   rx_eval;

  // saturating add on counters
  function automatic logic [CW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW-1:0] s;
    s = a + b;
    if (s > SW'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return s[CW-1:0];
  endfunction

  // one direction's housekeeping step and window evaluation
  function automatic eval_t evaluate(input logic is_tx, input logic [SCHED_W-1:0] now,
                                     input dir_t cur);
    eval_t              r;
    logic [LIMIT_W-1:0] high;
    logic [SCHED_W-1:0] maxc;
    logic [CW-1:0]      elap;
    r      = '0;
    r.d    = cur;
    high   = (is_tx || cur.sched != '0) ? used_high_limit : rx_initial_high_limit;
    maxc   = is_tx ? tx_max_cells : rx_max_cells;
    r.d.sched = now;
    if (!is_tx && now == '0) begin
      elap = sat_add(SW'(cur.elap), SW'(1));
    end else begin
      elap = sat_add(SW'(cur.elap), SW'(now));
    end
    r.d.elap = elap;
    if (CMPW'(elap) >= CMPW'(window_cells)) begin
      if (CMPW'(cur.used) > CMPW'(high) && now < maxc &&
          cur.req < ({1'b0, now} + 9'd1)) begin
        r.d.req = {1'b0, now} + 9'd1;
      end else if (CMPW'(cur.used) < CMPW'(used_low_limit) &&
                   ((is_tx && now > 8'd1) || (!is_tx && now > 8'd0)) &&
                   cur.req > ({1'b0, now} - 9'd1)) begin
        r.d.req = {1'b0, now} - 9'd1;
      end else if (is_tx && cur.used == '0 && now > 8'd0) begin
        r.keep = 1'b1;
      end
      r.d.elap = '0;
      r.d.used = '0;
    end
    return r;
  endfunction

  // handshake
  assign out_ready = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;

  // per-direction window evaluation
  always_comb begin
    tx_eval = evaluate(1'b1, s1_tx_now, tx);
    rx_eval = evaluate(1'b0, s1_rx_now, rx);
  end

  // next state and result for the held request
  always_comb begin
    tx_next              = tx;
    rx_next              = rx;
    keep_alive_flag_next = keep_alive_flag;
    request_next         = REQ_NONE;
    case (s1_action)
      ACT_RESET: begin
        keep_alive_flag_next = 1'b0;
        tx_next.sched = '0;
        tx_next.elap  = '0;
        tx_next.used  = '0;
        rx_next.sched = '0;
        rx_next.elap  = '0;
        rx_next.used  = '0;
        if (s1_clear_required) begin
          tx_next.req = 9'd1;
          rx_next.req = 9'd0;
        end
      end
      ACT_TX_USED: begin
        tx_next.used = sat_add(SW'(tx.used), SW'(s1_used_count));
      end
      ACT_RX_USED: begin
        rx_next.used = sat_add(SW'(rx.used), SW'(1));
      end
      ACT_HOUSEKEEP: begin
        if (s1_parent_present) begin
          tx_next = tx_eval.d;
          rx_next = rx_eval.d;
          if (tx_eval.keep) begin
            keep_alive_flag_next = 1'b1;
          end
        end
      end
      ACT_TRIGGER: begin
        if ({1'b0, tx.sched} < tx.req) begin
          request_next = REQ_ADD_TX;
        end else if ({1'b0, rx.sched} < rx.req) begin
          request_next = REQ_ADD_RX;
        end else if ({1'b0, tx.sched} > tx.req) begin
          request_next = REQ_DEL_TX;
        end else if ({1'b0, rx.sched} > rx.req) begin
          request_next = REQ_DEL_RX;
        end else if (keep_alive_flag) begin
          request_next         = REQ_KEEP_ALIVE;
          keep_alive_flag_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      tx              <= '{sched: '0, req: 9'd1, elap: '0, used: '0};
      rx              <= '{sched: '0, req: 9'd0, elap: '0, used: '0};
      keep_alive_flag <= 1'b0;
    end else begin
      if (!s1_valid || out_ready) begin
        s1_valid <= in_valid;
      end
      if (out_ready) begin
        out_valid <= s1_valid;
      end
      if (s1_fire) begin
        tx              <= tx_next;
        rx              <= rx_next;
        keep_alive_flag <= keep_alive_flag_next;
      end
    end
  end

  // input payload register
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action         <= action;
      s1_clear_required <= clear_required;
      s1_used_count     <= used_count;
      s1_parent_present <= parent_present;
      s1_tx_now         <= tx_scheduled_now;
      s1_rx_now         <= rx_scheduled_now;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      request            <= request_next;
      tx_required_out    <= tx_next.req;
      rx_required_out    <= rx_next.req;
      keep_alive_pending <= keep_alive_flag_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_cells          <= WINDOW_CELLS_RESET;
      used_high_limit       <= USED_HIGH_LIMIT_RESET;
      used_low_limit        <= USED_LOW_LIMIT_RESET;
      rx_initial_high_limit <= RX_INIT_HIGH_RESET;
      tx_max_cells          <= TX_MAX_CELLS_RESET;
      rx_max_cells          <= RX_MAX_CELLS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WINDOW_CELLS:    window_cells          <= cfg_data;
        CFG_USED_HIGH_LIMIT: used_high_limit       <= cfg_data;
        CFG_USED_LOW_LIMIT:  used_low_limit        <= cfg_data;
        CFG_RX_INIT_HIGH:    rx_initial_high_limit <= cfg_data;
        CFG_TX_MAX_CELLS:    tx_max_cells          <= cfg_data[SCHED_W-1:0];
        CFG_RX_MAX_CELLS:    rx_max_cells          <= cfg_data[SCHED_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: sim/cell_count_adaptation_tb.sv
// cell_count_adaptation_tb: self-checking bench for the cell count adaptation block
// holds its own request-level predictor, random request stimulus and result checker
// depends on rtl/cca_pkg.sv and rtl/cell_count_adaptation.sv
`timescale 1ns / 1ps

module cell_count_adaptation_tb;
  import cca_pkg::*;

  localparam int CNT_W       = COUNTER_WIDTH_DEFAULT;
  localparam int CNT_MAX     = (1 << CNT_W) - 1;
  localparam int TX_DIR      = 0;
  localparam int RX_DIR      = 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_IDLE    = 17;
  // first action code the block does not decode
  localparam logic [ACTION_W-1:0] ACT_SPARE = ACT_TRIGGER + 3'd1;

  typedef struct packed {
    logic [ACTION_W-1:0]     action;
    logic                    clear;
    logic [USED_COUNT_W-1:0] used;
    logic                    parent;
    logic [SCHED_W-1:0]      tx_now;
    logic [SCHED_W-1:0]      rx_now;
  } cca_item_t;

  typedef struct packed {
    logic [REQUEST_W-1:0]  req;
    logic [REQUIRED_W-1:0] tx_req;
    logic [REQUIRED_W-1:0] rx_req;
    logic                  keep_alive;
  } cca_result_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [ACTION_W-1:0] action;
  logic clear_required;
  logic [USED_COUNT_W-1:0] used_count;
  logic parent_present;
  logic [SCHED_W-1:0] tx_scheduled_now;
  logic [SCHED_W-1:0] rx_scheduled_now;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [REQUEST_W-1:0] request;
  logic [REQUIRED_W-1:0] tx_required_out;
  logic [REQUIRED_W-1:0] rx_required_out;
  logic keep_alive_pending;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state; the arrays are indexed by direction
  int scheduled[2];
  int required[2];
  int elapsed[2];
  int used_cells[2];
  bit keep_alive;
  int window_cells;
  int high_limit;
  int low_limit;
  int rx_init_high;
  int max_cells[2];

  cca_result_t pending_results[$];
  int failures;
  int cycles;
  bit send_quiet;
  bit recv_quiet;

  cell_count_adaptation #(.COUNTER_WIDTH(CNT_W)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .clear_required(clear_required), .used_count(used_count),
    .parent_present(parent_present), .tx_scheduled_now(tx_scheduled_now),
    .rx_scheduled_now(rx_scheduled_now),
    .out_valid(out_valid), .out_stall(out_stall),
    .request(request), .tx_required_out(tx_required_out),
    .rx_required_out(rx_required_out), .keep_alive_pending(keep_alive_pending),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("cell_count_adaptation_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor

  function automatic int sat_add(input int a, input int b);
    return (a + b > CNT_MAX) ? CNT_MAX : a + b;
  endfunction

  function automatic void clear_counts(input bit clear_req);
    keep_alive = 1'b0;
    for (int d = 0; d < 2; d++) begin
      scheduled[d] = 0;
      elapsed[d] = 0;
      used_cells[d] = 0;
    end
    if (clear_req) begin
      required[TX_DIR] = 1;
      required[RX_DIR] = 0;
    end
  endfunction

  function automatic void reset_predictor();
    window_cells = WINDOW_CELLS_RESET;
    high_limit = USED_HIGH_LIMIT_RESET;
    low_limit = USED_LOW_LIMIT_RESET;
    rx_init_high = RX_INIT_HIGH_RESET;
    max_cells[TX_DIR] = TX_MAX_CELLS_RESET;
    max_cells[RX_DIR] = RX_MAX_CELLS_RESET;
    clear_counts(1'b1);
  endfunction

  // load a fresh scheduled count, advance elapsed and close the window if due
  function automatic void advance_window(input int d, input int now);
    int high;
    int floor_sched;
    // rx picks its high limit from the count held before this update
    if (d == TX_DIR) high = high_limit;
    else high = (scheduled[d] > 0) ? high_limit : rx_init_high;
    floor_sched = (d == TX_DIR) ? 1 : 0;
    scheduled[d] = now;
    if (d == RX_DIR && now == 0) elapsed[d] = sat_add(elapsed[d], 1);
    else elapsed[d] = sat_add(elapsed[d], now);
    if (elapsed[d] < window_cells) return;
    if (used_cells[d] > high && now < max_cells[d] && required[d] < now + 1) begin
      required[d] = now + 1;
    end else if (used_cells[d] < low_limit && now > floor_sched &&
                 required[d] > now - 1) begin
      required[d] = now - 1;
    end else if (d == TX_DIR && used_cells[d] == 0 && now > 0) begin
      keep_alive = 1'b1;
    end
    elapsed[d] = 0;
    used_cells[d] = 0;
  endfunction

  function automatic cca_result_t predict_result(input cca_item_t it);
    cca_result_t res;
    res.req = REQ_NONE;
    case (it.action)
      ACT_RESET: clear_counts(it.clear);
      ACT_TX_USED: used_cells[TX_DIR] = sat_add(used_cells[TX_DIR], it.used);
      ACT_RX_USED: used_cells[RX_DIR] = sat_add(used_cells[RX_DIR], 1);
      ACT_HOUSEKEEP: begin
        if (it.parent) begin
          advance_window(TX_DIR, it.tx_now);
          advance_window(RX_DIR, it.rx_now);
        end
      end
      ACT_TRIGGER: begin
        // fixed priority: add tx, add rx, delete tx, delete rx, keep-alive
        if (scheduled[TX_DIR] < required[TX_DIR]) begin
          res.req = REQ_ADD_TX;
        end else if (scheduled[RX_DIR] < required[RX_DIR]) begin
          res.req = REQ_ADD_RX;
        end else if (scheduled[TX_DIR] > required[TX_DIR]) begin
          res.req = REQ_DEL_TX;
        end else if (scheduled[RX_DIR] > required[RX_DIR]) begin
          res.req = REQ_DEL_RX;
        end else if (keep_alive) begin
          res.req = REQ_KEEP_ALIVE;
          keep_alive = 1'b0;
        end
      end
      default: ;
    endcase
    res.tx_req = REQUIRED_W'(required[TX_DIR]);
    res.rx_req = REQUIRED_W'(required[RX_DIR]);
    res.keep_alive = keep_alive;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers

  function automatic cca_item_t mk_item(input logic [ACTION_W-1:0] act, input int clr,
                                        input int used, input int par,
                                        input int tx_now, input int rx_now);
    cca_item_t it;
    it.action = act;
    it.clear = clr[0];
    it.used = used[USED_COUNT_W-1:0];
    it.parent = par[0];
    it.tx_now = tx_now[SCHED_W-1:0];
    it.rx_now = rx_now[SCHED_W-1:0];
    return it;
  endfunction

  // scheduled count for an update, half the time close to what is currently required
  function automatic logic [SCHED_W-1:0] pick_sched(input int d);
    int k;
    int v;
    k = $urandom_range(0, 9);
    if (k < 5) begin
      v = required[d] + int'($urandom_range(0, 2)) - 1;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
    end else if (k < 7) begin
      v = 0;
    end else if (k < 9) begin
      v = $urandom_range(0, 20);
    end else begin
      v = $urandom_range(0, 255);
    end
    return v[SCHED_W-1:0];
  endfunction

  function automatic cca_item_t random_item();
    cca_item_t it;
    int pick;
    int k;
    // fields the action ignores still carry noise
    it.clear = 1'($urandom_range(0, 1));
    it.used = USED_COUNT_W'($urandom);
    it.parent = 1'($urandom_range(0, 1));
    it.tx_now = SCHED_W'($urandom);
    it.rx_now = SCHED_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      it.action = ACT_RESET;
    end else if (pick < 5) begin
      it.action = ACT_SPARE + ACTION_W'($urandom_range(0, 2));
    end else if (pick < 30) begin
      it.action = ACT_TX_USED;
      k = $urandom_range(0, 19);
      if (k == 0) it.used = '1;
      else if (k > 2) it.used = USED_COUNT_W'($urandom_range(0, 40));
    end else if (pick < 50) begin
      it.action = ACT_RX_USED;
    end else if (pick < 78) begin
      it.action = ACT_HOUSEKEEP;
      it.parent = ($urandom_range(0, 9) != 0);
      it.tx_now = pick_sched(TX_DIR);
      it.rx_now = pick_sched(RX_DIR);
    end else begin
      it.action = ACT_TRIGGER;
    end
    return it;
  endfunction

  // send one request after a random gap; valid stays high for a back-to-back follower
  task automatic send_item(input cca_item_t it);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= it.action;
    clear_required <= it.clear;
    used_count <= it.used;
    parent_present <= it.parent;
    tx_scheduled_now <= it.tx_now;
    rx_scheduled_now <= it.rx_now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_result(it));
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_item(random_item());
  endtask

  // stop sending and wait until every expected result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      CFG_WINDOW_CELLS:    window_cells = value;
      CFG_USED_HIGH_LIMIT: high_limit = value;
      CFG_USED_LOW_LIMIT:  low_limit = value;
      CFG_RX_INIT_HIGH:    rx_init_high = value;
      CFG_TX_MAX_CELLS:    max_cells[TX_DIR] = value;
      CFG_RX_MAX_CELLS:    max_cells[RX_DIR] = value;
      default: ;
    endcase
  endtask

  task automatic load_settings(input int win, input int high, input int low,
                               input int rx_init, input int tx_max, input int rx_max);
    drain_results();
    write_reg(CFG_WINDOW_CELLS, win);
    write_reg(CFG_USED_HIGH_LIMIT, high);
    write_reg(CFG_USED_LOW_LIMIT, low);
    write_reg(CFG_RX_INIT_HIGH, rx_init);
    write_reg(CFG_TX_MAX_CELLS, tx_max);
    write_reg(CFG_RX_MAX_CELLS, rx_max);
    cfg_write <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests

  // register defaults: spare actions, used saturation, no parent, idle rx, triggers
  task automatic test_directed_defaults();
    send_item(mk_item(ACT_TRIGGER, 0, 0, 0, 0, 0));
    send_item(mk_item(ACT_SPARE, 1, 16'hffff, 1, 255, 255));
    send_item(mk_item(ACT_SPARE + 3'd1, 1, 16'hffff, 1, 255, 255));
    send_item(mk_item(ACT_SPARE + 3'd2, 1, 16'hffff, 1, 255, 255));
    send_item(mk_item(ACT_TX_USED, 0, 16'hffff, 0, 0, 0));
    send_item(mk_item(ACT_TX_USED, 0, 16'hffff, 0, 0, 0));
    send_item(mk_item(ACT_TX_USED, 0, 0, 0, 0, 0));
    send_item(mk_item(ACT_RX_USED, 0, 0, 0, 0, 0));
    send_item(mk_item(ACT_HOUSEKEEP, 0, 0, 0, 255, 255));
    send_item(mk_item(ACT_HOUSEKEEP, 0, 0, 1, 255, 0));
    send_item(mk_item(ACT_HOUSEKEEP, 0, 0, 1, 100, 0));
    send_item(mk_item(ACT_TRIGGER, 0, 0, 0, 0, 0));
    send_item(mk_item(ACT_RESET, 0, 0, 0, 0, 0));
    send_item(mk_item(ACT_RESET, 1, 0, 0, 0, 0));
    drain_results();
  endtask

  // each register at a low and a high setting, random traffic under each
  task automatic test_limit_extremes();
    load_settings(1, 0, 1024, 0, 255, 255);
    send_random(100);
    load_settings(1024, 1024, 0, 1024, 0, 0);
    send_random(100);
    drain_results();
  endtask

  // window of zero: every update evaluates; walks add tx, add rx, delete rx and keep-alive
  task automatic test_zero_window();
    load_settings(0, 2, 1, 3, 8, 8);
    send_item(mk_item(ACT_RESET, 1, 0, 0, 0, 0));
    send_item(mk_item(ACT_HOUSEKEEP, 0, 0, 1, 1, 0));
    repeat (4) send_item(mk_item(ACT_RX_USED, 0, 0, 0, 0, 0));
    send_item(mk_item(ACT_HOUSEKEEP, 0, 0, 1, 1, 0));
    send_item(mk_item(ACT_TRIGGER, 0, 0, 0, 0, 0));
    send_item(mk_item(ACT_HOUSEKEEP, 0, 0, 1, 1, 1));
    send_item(mk_item(ACT_TRIGGER, 0, 0, 0, 0, 0));
    send_item(mk_item(ACT_HOUSEKEEP, 0, 0, 1, 1, 0));
    send_item(mk_item(ACT_TRIGGER, 0, 0, 0, 0, 0));
    // rx high limit follows the previous scheduled count, not the new one
    send_item(mk_item(ACT_HOUSEKEEP, 0, 0, 1, 1, 2));
    repeat (3) send_item(mk_item(ACT_RX_USED, 0, 0, 0, 0, 0));
    send_item(mk_item(ACT_HOUSEKEEP, 0, 0, 1, 1, 2));
    send_item(mk_item(ACT_TX_USED, 0, 3, 0, 0, 0));
    send_item(mk_item(ACT_HOUSEKEEP, 0, 0, 1, 1, 2));
    send_item(mk_item(ACT_TRIGGER, 0, 0, 0, 0, 0));
    send_random(80);
    drain_results();
  endtask

  // random register settings, some phases without any idling
  task automatic test_random_settings();
    int win;
    int maxc;
    for (int p = 0; p < 6; p++) begin
      win = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 120);
      maxc = (p == 5) ? 255 : $urandom_range(1, 24);
      load_settings(win, $urandom_range(0, 40), $urandom_range(0, 30),
                    $urandom_range(0, 40), maxc, $urandom_range(1, maxc));
      send_quiet = (p == 2 || p == 4);
      recv_quiet = (p == 2 || p == 3);
      send_random(120);
    end
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    drain_results();
  endtask

  // sender holds off mid-stream until every result is back
  task automatic test_drain_pause();
    load_settings(40, 10, 4, 6, 12, 12);
    send_random(30);
    drain_results();
    send_random(30);
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // result checking with random receiver stalls

  always @(posedge clk) begin : result_check
    cca_result_t got;
    cca_result_t want;
    int hold_left;
    if (!rst && out_valid && !out_stall) begin
      got = {request, tx_required_out, rx_required_out, keep_alive_pending};
      if (pending_results.size() == 0) begin
        failures = failures + 1;
        if (failures <= 10)
          $display("%t: result with nothing expected: request %0d tx %0d rx %0d keep %0d",
                   $realtime, got.req, got.tx_req, got.rx_req, got.keep_alive);
      end else begin
        want = pending_results.pop_front();
        if (got.req !== want.req || got.tx_req !== want.tx_req ||
            got.rx_req !== want.rx_req || got.keep_alive !== want.keep_alive) begin
          failures = failures + 1;
          if (failures <= 10)
            $display("%t: mismatch: expected request %0d tx %0d rx %0d keep %0d, got %0d %0d %0d %0d",
                     $realtime, want.req, want.tx_req, want.rx_req, want.keep_alive,
                     got.req, got.tx_req, got.rx_req, got.keep_alive);
        end
      end
      hold_left = recv_quiet ? 0 : $urandom_range(0, MAX_IDLE);
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
    end
    out_stall <= (hold_left != 0);
  end

  // ---------------------------------------------------------------------------
  // main sequence

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_RESET;
    clear_required = 1'b0;
    used_count = '0;
    parent_present = 1'b0;
    tx_scheduled_now = '0;
    rx_scheduled_now = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_WINDOW_CELLS;
    cfg_data = '0;
    failures = 0;
    cycles = 0;
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    reset_predictor();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_defaults();
    test_limit_extremes();
    test_zero_window();
    test_random_settings();
    test_drain_pause();

    drain_results();
    repeat (6) @(posedge clk);
    if (failures == 0) begin
      $display("cell_count_adaptation_tb: clean");
    end else begin
      $display("cell_count_adaptation_tb: errors");
    end
    $finish;
  end

endmodule
